// ----- rtl/core/psc_pkg.sv -----
// Shared types and constants for the prime sieve counter.
`timescale 1ns / 1ps

package psc_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned LIMIT_W     = 17;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned FIRST_PRIME = 2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Control flags that travel with each candidate down the cell chain
  typedef struct packed {
    logic valid;  // a candidate occupies this slot
    logic alive;  // no cell has found a divisor yet
    logic taken;  // a cell captured this candidate as its prime
    logic last;   // candidate equals the limit
  } psc_flags_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FEED  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } psc_state_t;

endpackage

// ----- rtl/core/psc_cell.sv -----
// One sieve cell: holds a prime and the residue of the next candidate modulo it.
`timescale 1ns / 1ps

module psc_cell
  import psc_pkg::*;
#(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned P_W   = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  psc_flags_t       flags_in,
  input  logic [NUM_W-1:0] num_in,
  output psc_flags_t       flags_out,
  output logic [NUM_W-1:0] num_out
);

  logic             full_r, full_nxt;
  logic [P_W-1:0]   prime_r, prime_nxt;
  logic [P_W-1:0]   res_r, res_nxt;
  psc_flags_t       flags_r, flags_nxt;
  logic [NUM_W-1:0] num_r;

  // Test the candidate against the held prime, or capture it as the new prime
  always_comb begin
    full_nxt  = full_r;
    prime_nxt = prime_r;
    res_nxt   = res_r;
    flags_nxt = flags_in;
    if (flags_in.valid) begin
      if (full_r) begin
        if (res_r == '0) begin
          flags_nxt.alive = 1'b0;
        end
        if (res_r == prime_r - P_W'(1)) begin
          res_nxt = '0;
        end else begin
          res_nxt = res_r + P_W'(1);
        end
      end else if (flags_in.alive && !flags_in.taken) begin
        full_nxt        = 1'b1;
        prime_nxt       = P_W'(num_in);
        res_nxt         = P_W'(1);
        flags_nxt.taken = 1'b1;
      end
    end
    if (clear) begin
      full_nxt        = 1'b0;
      flags_nxt.valid = 1'b0;
    end
  end

  // Control state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= 1'b0;
      flags_r <= '0;
    end else begin
      full_r  <= full_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    prime_r <= prime_nxt;
    res_r   <= res_nxt;
    num_r   <= num_in;
  end

  assign flags_out = flags_r;
  assign num_out   = num_r;

endmodule

// ----- rtl/core/prime_sieve_counter.sv -----
// Top level of the prime sieve counter: feeder, cell chain and tally.
//
// Usage: a request on in_valid/in_ready carries in_limit; one item comes back
// on out_valid/out_ready with out_prime_count, the number of primes 2..limit.
// Limits above MAX_LIMIT are taken as MAX_LIMIT; limits below two give zero.
// Candidates 2..n enter a chain of cells one per cycle. Each cell keeps one
// prime and the running residue of the candidate stream modulo that prime;
// an empty cell takes the first surviving candidate as its prime. The chain
// holds as many cells as there are primes up to sqrt(MAX_LIMIT), so any
// candidate that leaves the chain unmarked is prime and is tallied.
// For limits below two the result is offered in the cycle after the request.
// One request is handled at a time: in_ready is high only while the block
// is idle. Reset empties the chain and drops any pending result. A stalled
// receiver holds the result in the output register; no new request is taken
// until it is delivered. Each new request clears every cell at once.
`timescale 1ns / 1ps

module prime_sieve_counter
  import psc_pkg::*;
#(
  parameter int unsigned MAX_LIMIT = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LIMIT_W-1:0] in_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] out_prime_count
);

  // Integer square root at elaboration
  function automatic int unsigned isqrt(input int unsigned v);
    int unsigned s;
    s = 0;
    while ((s + 1) * (s + 1) <= v) begin
      s = s + 1;
    end
    return s;
  endfunction

  // Number of primes up to v at elaboration
  function automatic int unsigned primes_upto(input int unsigned v);
    int unsigned cnt;
    int unsigned r;
    bit          is_p;
    cnt = 0;
    for (int unsigned k = 2; k <= v; k++) begin
      is_p = 1'b1;
      for (int unsigned d = 2; is_p && d * d <= k; d++) begin
        // Reduce k by repeated subtraction of d
        r = k;
        while (r >= d) begin
          r = r - d;
        end
        if (r == 0) begin
          is_p = 1'b0;
        end
      end
      if (is_p) begin
        cnt = cnt + 1;
      end
    end
    return cnt;
  endfunction

  localparam int unsigned NUM_W  = $clog2(MAX_LIMIT + 1);
  localparam int unsigned ROOT   = isqrt(MAX_LIMIT);
  localparam int unsigned P_W    = $clog2(ROOT + 1);
  localparam int unsigned NCELLS = primes_upto(ROOT);

  psc_state_t         state_r, state_nxt;
  logic [NUM_W-1:0]   n_r, n_nxt;
  logic [NUM_W-1:0]   m_r, m_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   lim_sat;
  logic               accept;
  logic               clear;

  psc_flags_t         chain_flags [NCELLS+1];
  logic [NUM_W-1:0]   chain_num   [NCELLS+1];
  psc_flags_t         tail;

  assign in_ready        = (state_r == S_IDLE);
  assign accept          = in_valid && in_ready;
  assign clear           = accept;
  assign out_valid       = (state_r == S_DONE);
  assign out_prime_count = cnt_r;
  assign tail            = chain_flags[NCELLS];

  // Saturate the limit to the store size
  always_comb begin
    if (32'(in_limit) > 32'(MAX_LIMIT)) begin
      lim_sat = NUM_W'(MAX_LIMIT);
    end else begin
      lim_sat = NUM_W'(in_limit);
    end
  end

  // Inject the current candidate at the head of the chain
  assign chain_flags[0] = {(state_r == S_FEED), 1'b1, 1'b0, (m_r == n_r)};
  assign chain_num[0]   = m_r;

  // Cell chain
  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    psc_cell #(
      .NUM_W (NUM_W),
      .P_W   (P_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clear),
      .flags_in  (chain_flags[g]),
      .num_in    (chain_num[g]),
      .flags_out (chain_flags[g+1]),
      .num_out   (chain_num[g+1])
    );
  end

  // Sequence a request: feed candidates, drain the chain, hold the result
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    cnt_nxt   = cnt_r;
    if (tail.valid && tail.alive && cnt_r != COUNT_MAX) begin
      cnt_nxt = cnt_r + COUNT_W'(1);
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          n_nxt   = lim_sat;
          m_nxt   = NUM_W'(FIRST_PRIME);
          if (in_limit < LIMIT_W'(FIRST_PRIME)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FEED;
          end
        end
      end
      S_FEED: begin
        if (m_r == n_r) begin
          state_nxt = S_DRAIN;
        end else begin
          m_nxt = m_r + NUM_W'(1);
        end
      end
      S_DRAIN: begin
        if (tail.valid && tail.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    m_r <= m_nxt;
  end

  // The chain is empty whenever a result is offered
  a_done_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !tail.valid)
    else $error("candidate still in chain while result is offered");

  // A limit below two answers at once with zero
  a_small_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_limit < LIMIT_W'(FIRST_PRIME)) |=> (out_valid && cnt_r == '0))
    else $error("small limit did not return zero at once");

  // The feed never runs past the limit
  a_feed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEED) |-> (m_r <= n_r))
    else $error("candidate counter passed the limit");

endmodule
